[design/iekq_pkg.sv]
// ----------------------------------------------------------------------------
// iekq_pkg
// Shared types and constants for the input event key queue.
// ----------------------------------------------------------------------------
package iekq_pkg;

  // request codes on the func field
  localparam logic [2:0] FUNC_RAW    = 3'd0;
  localparam logic [2:0] FUNC_REPEAT = 3'd1;
  localparam logic [2:0] FUNC_POP    = 3'd2;
  localparam logic [2:0] FUNC_CLEAR  = 3'd3;
  localparam logic [2:0] FUNC_QUERY  = 3'd4;

  // event classes
  localparam logic [4:0] TYPE_SYN = 5'd0;
  localparam logic [4:0] TYPE_KEY = 5'd1;
  localparam logic [4:0] TYPE_REL = 5'd2;
  localparam logic [4:0] TYPE_ABS = 5'd3;

  // axis and key codes
  localparam logic [15:0] AXIS_Y   = 16'd1;
  localparam logic [15:0] VOL_DOWN = 16'd114;
  localparam logic [15:0] VOL_UP   = 16'd115;

  localparam int KEY_W   = 10;
  localparam int COUNT_W = 9;

  localparam logic [7:0] THRESHOLD_RST = 8'd3;

  // classified operation handed from front to back
  typedef enum logic [2:0] {
    OP_NONE,
    OP_KEY,
    OP_POP,
    OP_CLEAR,
    OP_QUERY
  } op_t;

  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] code;
    logic [7:0]       state_byte;
    logic             store_state;
    logic             press;
    logic             armed;
    logic [KEY_W-1:0] qkey;
    logic             qkey_ok;
  } cmd_t;

  // one result transaction
  typedef struct packed {
    logic               key_accepted;
    logic               key_dropped;
    logic               popped_valid;
    logic [KEY_W-1:0]   popped_key;
    logic [COUNT_W-1:0] queue_count;
    logic [7:0]         key_state;
    logic               repeat_armed;
  } res_t;

endpackage

[design/iekq_fifo2.sv]
// ----------------------------------------------------------------------------
// iekq_fifo2
// Two-entry register queue used between the stages of the block.
// ----------------------------------------------------------------------------
module iekq_fifo2 #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  logic [WIDTH-1:0] mem_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == 2'd2);
  assign empty   = (count_r == 2'd0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // payload storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[design/iekq_front.sv]
// ----------------------------------------------------------------------------
// iekq_front
// Request classifier: motion accumulation, held-key tracking, threshold
// register, and translation of each request into a back-end operation.
// ----------------------------------------------------------------------------
module iekq_front #(
  parameter int KEY_COUNT = 768
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data,
  input  logic                accept,
  input  logic [2:0]          func,
  input  logic [4:0]          event_type,
  input  logic [15:0]         event_code,
  input  logic signed [31:0]  event_value,
  input  logic [9:0]          query_key,
  output iekq_pkg::cmd_t      cmd
);

  logic [7:0]          thr_r;
  logic signed [8:0]   sum_r, sum_nxt;
  logic                held_r, held_nxt;
  logic [9:0]          last_key_r, last_key_nxt;

  logic                is_vol;
  logic                held_hit;
  logic                value_pos;
  logic signed [33:0]  sum_ext;
  logic signed [33:0]  thr_pos;
  logic signed [33:0]  thr_neg;

  assign is_vol    = (event_code == iekq_pkg::VOL_UP) || (event_code == iekq_pkg::VOL_DOWN);
  assign held_hit  = (event_type == iekq_pkg::TYPE_KEY) && is_vol && (event_value == 32'sd1);
  assign value_pos = !event_value[31] && (event_value != 32'sd0);
  assign sum_ext   = {{25{sum_r[8]}}, sum_r} + {{2{event_value[31]}}, event_value};
  assign thr_pos   = {26'd0, thr_r};
  assign thr_neg   = -thr_pos;

  // classify the request and compute next front state
  always_comb begin
    cmd             = '0;
    cmd.op          = iekq_pkg::OP_NONE;
    cmd.qkey        = query_key;
    cmd.qkey_ok     = ({1'b0, query_key} < 11'(KEY_COUNT));
    sum_nxt         = sum_r;
    held_nxt        = held_r;
    last_key_nxt    = last_key_r;
    unique case (func)
      iekq_pkg::FUNC_RAW: begin
        held_nxt = held_hit;
        if (held_hit) begin
          last_key_nxt = event_code[9:0];
        end
        if (event_type == iekq_pkg::TYPE_SYN) begin
          cmd.op = iekq_pkg::OP_NONE;
        end else if (event_type == iekq_pkg::TYPE_REL) begin
          if (event_code == iekq_pkg::AXIS_Y) begin
            if (sum_ext > thr_pos) begin
              cmd.op    = iekq_pkg::OP_KEY;
              cmd.code  = iekq_pkg::VOL_DOWN[9:0];
              cmd.press = 1'b1;
              sum_nxt   = '0;
            end else if (sum_ext < thr_neg) begin
              cmd.op    = iekq_pkg::OP_KEY;
              cmd.code  = iekq_pkg::VOL_UP[9:0];
              cmd.press = 1'b1;
              sum_nxt   = '0;
            end else begin
              sum_nxt = sum_ext[8:0];
            end
          end
        end else if (event_type == iekq_pkg::TYPE_ABS && is_vol) begin
          // synthesized key: queued but not recorded
          cmd.op    = iekq_pkg::OP_KEY;
          cmd.code  = event_code[9:0];
          cmd.press = value_pos;
        end else begin
          sum_nxt = '0;
          if (event_type == iekq_pkg::TYPE_KEY && event_code < 16'(KEY_COUNT)) begin
            cmd.op          = iekq_pkg::OP_KEY;
            cmd.code        = event_code[9:0];
            cmd.store_state = 1'b1;
            cmd.state_byte  = event_value[7:0];
            cmd.press       = value_pos;
          end
        end
      end
      iekq_pkg::FUNC_REPEAT: begin
        if (held_r) begin
          sum_nxt         = '0;
          cmd.op          = iekq_pkg::OP_KEY;
          cmd.code        = last_key_r;
          cmd.store_state = 1'b1;
          cmd.state_byte  = 8'd1;
          cmd.press       = 1'b1;
        end
      end
      iekq_pkg::FUNC_POP:   cmd.op = iekq_pkg::OP_POP;
      iekq_pkg::FUNC_CLEAR: cmd.op = iekq_pkg::OP_CLEAR;
      iekq_pkg::FUNC_QUERY: cmd.op = iekq_pkg::OP_QUERY;
      default:              cmd.op = iekq_pkg::OP_NONE;
    endcase
    cmd.armed = held_nxt;
  end

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= iekq_pkg::THRESHOLD_RST;
    end else if (cfg_we) begin
      thr_r <= cfg_data;
    end
  end

  // front state advances on each accepted transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r      <= '0;
      held_r     <= 1'b0;
      last_key_r <= '0;
    end else if (accept) begin
      sum_r      <= sum_nxt;
      held_r     <= held_nxt;
      last_key_r <= last_key_nxt;
    end
  end

endmodule

[design/iekq_back.sv]
// ----------------------------------------------------------------------------
// iekq_back
// Executes classified operations: key ring queue, key-state table and
// result assembly. Clears the key-state table after reset.
// ----------------------------------------------------------------------------
module iekq_back #(
  parameter int QUEUE_DEPTH = 256,
  parameter int KEY_COUNT   = 768
) (
  input  logic            clk,
  input  logic            rst_n,
  input  iekq_pkg::cmd_t  cmd,
  input  logic            cmd_empty,
  output logic            cmd_pop,
  output iekq_pkg::res_t  res,
  output logic            res_push,
  input  logic            res_full,
  output logic            busy
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = $clog2(2 * QUEUE_DEPTH);
  localparam int AW = $clog2(KEY_COUNT);

  // memories
  logic [iekq_pkg::KEY_W-1:0] key_fifo [QUEUE_DEPTH];
  logic [7:0]                 key_table [KEY_COUNT];

  logic [PW-1:0]  head_r, head_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic           clr_busy_r;
  logic [AW-1:0]  clr_addr_r;
  logic           b2_valid_r, b2_valid_nxt;
  iekq_pkg::res_t b2_res_r, b2_res_nxt;
  logic           b2_sel_pop_r, b2_sel_pop_nxt;
  logic           b2_sel_qry_r, b2_sel_qry_nxt;
  logic [iekq_pkg::KEY_W-1:0] fifo_rd_r;
  logic [7:0]     tbl_rd_r;

  logic           fire;
  logic [SW-1:0]  wr_sum;
  logic [PW-1:0]  fifo_waddr;
  logic           fifo_we, fifo_re;
  logic           tbl_we, tbl_re;
  logic [CW+8:0]  count_ext;

  assign busy     = clr_busy_r;
  assign fire     = !cmd_empty && !clr_busy_r && (!b2_valid_r || !res_full);
  assign cmd_pop  = fire;
  assign res_push = b2_valid_r;

  // ring write position, wrapped once
  assign wr_sum     = SW'(head_r) + SW'(count_r);
  assign fifo_waddr = (wr_sum >= SW'(QUEUE_DEPTH)) ? PW'(wr_sum - SW'(QUEUE_DEPTH))
                                                   : PW'(wr_sum);
  assign count_ext  = {9'd0, count_nxt};

  // operation execute
  always_comb begin
    head_nxt       = head_r;
    count_nxt      = count_r;
    fifo_we        = 1'b0;
    fifo_re        = 1'b0;
    tbl_we         = 1'b0;
    tbl_re         = 1'b0;
    b2_res_nxt     = '0;
    b2_sel_pop_nxt = 1'b0;
    b2_sel_qry_nxt = 1'b0;
    if (fire) begin
      unique case (cmd.op)
        iekq_pkg::OP_KEY: begin
          b2_res_nxt.key_accepted = 1'b1;
          tbl_we = cmd.store_state;
          if (cmd.press) begin
            if (count_r != CW'(QUEUE_DEPTH)) begin
              fifo_we   = 1'b1;
              count_nxt = count_r + CW'(1);
            end else begin
              b2_res_nxt.key_dropped = 1'b1;
            end
          end
        end
        iekq_pkg::OP_POP: begin
          if (count_r != '0) begin
            fifo_re                 = 1'b1;
            b2_sel_pop_nxt          = 1'b1;
            b2_res_nxt.popped_valid = 1'b1;
            head_nxt  = (head_r == PW'(QUEUE_DEPTH - 1)) ? '0 : head_r + PW'(1);
            count_nxt = count_r - CW'(1);
          end
        end
        iekq_pkg::OP_CLEAR: begin
          count_nxt = '0;
        end
        iekq_pkg::OP_QUERY: begin
          tbl_re         = cmd.qkey_ok;
          b2_sel_qry_nxt = cmd.qkey_ok;
        end
        default: begin
        end
      endcase
      b2_res_nxt.queue_count  = count_ext[8:0];
      b2_res_nxt.repeat_armed = cmd.armed;
    end
  end

  // result stage occupancy
  always_comb begin
    if (fire) begin
      b2_valid_nxt = 1'b1;
    end else if (!res_full) begin
      b2_valid_nxt = 1'b0;
    end else begin
      b2_valid_nxt = b2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      count_r    <= '0;
      b2_valid_r <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      head_r     <= head_nxt;
      count_r    <= count_nxt;
      b2_valid_r <= b2_valid_nxt;
      if (clr_busy_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(KEY_COUNT - 1)) begin
          clr_busy_r <= 1'b0;
        end
      end
    end
  end

  // result stage payload
  always_ff @(posedge clk) begin
    if (fire) begin
      b2_res_r     <= b2_res_nxt;
      b2_sel_pop_r <= b2_sel_pop_nxt;
      b2_sel_qry_r <= b2_sel_qry_nxt;
    end
  end

  // key ring memory
  always_ff @(posedge clk) begin
    if (fifo_we) begin
      key_fifo[fifo_waddr] <= cmd.code;
    end
    if (fifo_re) begin
      fifo_rd_r <= key_fifo[head_r];
    end
  end

  // key-state memory, swept to zero after reset
  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      key_table[clr_addr_r] <= 8'd0;
    end else if (tbl_we) begin
      key_table[cmd.code[AW-1:0]] <= cmd.state_byte;
    end
    if (tbl_re) begin
      tbl_rd_r <= key_table[cmd.qkey[AW-1:0]];
    end
  end

  // merge memory read data into the result
  always_comb begin
    res            = b2_res_r;
    res.popped_key = b2_sel_pop_r ? fifo_rd_r : '0;
    res.key_state  = b2_sel_qry_r ? tbl_rd_r : 8'd0;
  end

endmodule

[design/input_event_key_queue_unit.sv]
// ----------------------------------------------------------------------------
// input_event_key_queue_unit
// Translates input events, repeat ticks and queue requests into key queue
// operations and returns one result transaction per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on a queue-like port: drive in_* with in_push high; the
//   transaction is taken on a clock edge where in_full is low. Every request
//   yields exactly one result, shown on out_* while out_empty is low and
//   taken on an edge where out_pop is high.
//   cfg_we/cfg_data write the motion threshold (reset value 3); write it
//   only while no request is in flight.
// Path and throughput:
//   A result passes the operation queue, result stage and result queue.
//   One request per cycle is sustained while out_pop drains the output:
//   each operation is a single pass through the back end with at most one
//   access to each of the key ring and the key-state table.
// Reset:
//   rst_n is synchronous. Afterwards in_full stays high while the
//   key-state table is swept to zero.
// Stalls:
//   When out_pop is held low, two results buffer at the output, one in the
//   result stage and two in the front queue; then in_full rises.
// ----------------------------------------------------------------------------
module input_event_key_queue_unit #(
  parameter int QUEUE_DEPTH = 256,
  parameter int KEY_COUNT   = 768
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [7:0]         cfg_data,
  input  logic               in_push,
  output logic               in_full,
  input  logic [2:0]         in_func,
  input  logic [4:0]         in_event_type,
  input  logic [15:0]        in_event_code,
  input  logic signed [31:0] in_event_value,
  input  logic [9:0]         in_query_key,
  output logic               out_empty,
  input  logic               out_pop,
  output logic               out_key_accepted,
  output logic               out_key_dropped,
  output logic               out_popped_valid,
  output logic [9:0]         out_popped_key,
  output logic [8:0]         out_queue_count,
  output logic [7:0]         out_key_state,
  output logic               out_repeat_armed
);

  localparam int CMD_W = $bits(iekq_pkg::cmd_t);
  localparam int RES_W = $bits(iekq_pkg::res_t);

  iekq_pkg::cmd_t front_cmd;
  iekq_pkg::cmd_t back_cmd;
  iekq_pkg::res_t back_res;
  iekq_pkg::res_t out_res;
  logic           accept;
  logic           cmdq_full, cmdq_empty, cmdq_pop;
  logic           resq_full, res_push;
  logic           back_busy;

  assign in_full = cmdq_full || back_busy;
  assign accept  = in_push && !in_full;

  // front: classify requests
  iekq_front #(
    .KEY_COUNT (KEY_COUNT)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_data    (cfg_data),
    .accept      (accept),
    .func        (in_func),
    .event_type  (in_event_type),
    .event_code  (in_event_code),
    .event_value (in_event_value),
    .query_key   (in_query_key),
    .cmd         (front_cmd)
  );

  // operation queue between front and back
  iekq_fifo2 #(
    .WIDTH (CMD_W)
  ) u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .wdata (front_cmd),
    .full  (cmdq_full),
    .pop   (cmdq_pop),
    .rdata (back_cmd),
    .empty (cmdq_empty)
  );

  // back: execute operations
  iekq_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .KEY_COUNT   (KEY_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (back_cmd),
    .cmd_empty (cmdq_empty),
    .cmd_pop   (cmdq_pop),
    .res       (back_res),
    .res_push  (res_push),
    .res_full  (resq_full),
    .busy      (back_busy)
  );

  // result queue
  iekq_fifo2 #(
    .WIDTH (RES_W)
  ) u_resq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (back_res),
    .full  (resq_full),
    .pop   (out_pop),
    .rdata (out_res),
    .empty (out_empty)
  );

  assign out_key_accepted = out_res.key_accepted;
  assign out_key_dropped  = out_res.key_dropped;
  assign out_popped_valid = out_res.popped_valid;
  assign out_popped_key   = out_res.popped_key;
  assign out_queue_count  = out_res.queue_count;
  assign out_key_state    = out_res.key_state;
  assign out_repeat_armed = out_res.repeat_armed;

endmodule

[design/iekq_checker.sv]
// ----------------------------------------------------------------------------
// iekq_checker
// Port-level checks for the input event key queue, bound to the top level.
// ----------------------------------------------------------------------------
module iekq_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_full,
  input logic               out_empty,
  input logic               out_key_accepted,
  input logic               out_key_dropped,
  input logic               out_popped_valid,
  input logic [9:0]         out_popped_key,
  input logic [8:0]         out_queue_count
);

  // reset empties the result side and starts the table sweep
  a_reset_idle: assert property (@(posedge clk) !rst_n |=> out_empty && in_full)
    else $error("block not idle after reset");

  // a pop result never also carries a key transaction
  a_pop_xor_key: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !(out_key_accepted && out_popped_valid))
    else $error("pop and key reported in one transaction");

  // a dropped press is always an accepted key with a non-empty queue
  a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_key_dropped) |-> (out_key_accepted && out_queue_count != 9'd0))
    else $error("drop without accepted key or with empty queue");

  // popped key reads zero when nothing was popped
  a_pop_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_popped_valid) |-> (out_popped_key == 10'd0))
    else $error("popped key set without a pop");

endmodule

bind input_event_key_queue_unit iekq_checker u_iekq_checker (.*);

[verif/tb_input_event_key_queue_unit.sv]
// ----------------------------------------------------------------------------
// tb_input_event_key_queue_unit
// Self-checking bench for the input event key queue. A queue of pending
// requests feeds a clocked driver; every accepted request is run through a
// cycle-free model of the key translator and ring, and a clocked monitor
// compares each result transaction field by field with the oldest
// prediction. Idle rates, long output stalls and threshold settings change
// from phase to phase.
// ----------------------------------------------------------------------------
module tb_input_event_key_queue_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUEUE_DEPTH = 256;
  localparam int KEY_COUNT   = 768;
  localparam int STALL_LIMIT = 4000;
  localparam int PHASE_ITEMS = 445;
  localparam int PRINT_LIMIT = 40;

  // request codes with no defined operation, and the top event class
  localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
  localparam logic [2:0] FUNC_SPARE_HI = 3'd7;
  localparam logic [4:0] TYPE_TOP      = 5'd31;

  typedef struct packed {
    logic [2:0]         func;
    logic [4:0]         ev_type;
    logic [15:0]        code;
    logic signed [31:0] value;
    logic [9:0]         qkey;
  } request_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [7:0]         cfg_data = '0;
  logic               in_push = 1'b0;
  logic               in_full;
  logic [2:0]         in_func = '0;
  logic [4:0]         in_event_type = '0;
  logic [15:0]        in_event_code = '0;
  logic signed [31:0] in_event_value = '0;
  logic [9:0]         in_query_key = '0;
  logic               out_empty;
  logic               out_pop = 1'b0;
  logic               out_key_accepted;
  logic               out_key_dropped;
  logic               out_popped_valid;
  logic [9:0]         out_popped_key;
  logic [8:0]         out_queue_count;
  logic [7:0]         out_key_state;
  logic               out_repeat_armed;

  input_event_key_queue_unit #(
    .QUEUE_DEPTH(QUEUE_DEPTH),
    .KEY_COUNT  (KEY_COUNT)
  ) DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_data        (cfg_data),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_func         (in_func),
    .in_event_type   (in_event_type),
    .in_event_code   (in_event_code),
    .in_event_value  (in_event_value),
    .in_query_key    (in_query_key),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_key_accepted(out_key_accepted),
    .out_key_dropped (out_key_dropped),
    .out_popped_valid(out_popped_valid),
    .out_popped_key  (out_popped_key),
    .out_queue_count (out_queue_count),
    .out_key_state   (out_key_state),
    .out_repeat_armed(out_repeat_armed)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // translator state as the block should hold it
  logic [7:0]  motion_limit = iekq_pkg::THRESHOLD_RST;
  longint      motion_sum;
  logic        vol_held;
  logic [9:0]  held_key;
  logic [9:0]  key_ring [QUEUE_DEPTH];
  int          ring_head;
  int          ring_count;
  logic [7:0]  key_states [KEY_COUNT];

  request_t         pending_requests[$];
  iekq_pkg::res_t   expected_results[$];
  request_t         offered;
  iekq_pkg::res_t   result_want;
  int          queued_items;
  int          send_idle_pct;
  int          recv_idle_pct;
  int          holds_asked;
  int          holds_done;
  int          hold_left;
  int          results_seen;
  int          mismatch_count;
  int          stall_cycles;

  // next result of the translator for one request, updating its state
  function automatic iekq_pkg::res_t key_event_result(input request_t req);
    iekq_pkg::res_t res;
    bit     have_key;
    bit     synth;
    bit     is_vol;
    int     kcode;
    longint kval;
    longint thr;
    longint s;
    res = '0;
    have_key = 1'b0;
    synth = 1'b0;
    is_vol = (req.code == iekq_pkg::VOL_UP) || (req.code == iekq_pkg::VOL_DOWN);
    kcode = int'(req.code);
    kval = longint'($signed(req.value));
    thr = longint'(motion_limit);
    case (req.func)
      iekq_pkg::FUNC_RAW: begin
        // only a volume press arms auto-repeat, anything else disarms it
        if (req.ev_type == iekq_pkg::TYPE_KEY && is_vol && kval == 1) begin
          vol_held = 1'b1;
          held_key = req.code[9:0];
        end else begin
          vol_held = 1'b0;
        end
        if (req.ev_type == iekq_pkg::TYPE_SYN) begin
        end else if (req.ev_type == iekq_pkg::TYPE_REL) begin
          // vertical motion accumulates until it passes the threshold
          if (req.code == iekq_pkg::AXIS_Y) begin
            s = motion_sum + kval;
            if (s > thr) begin
              have_key = 1'b1;
              synth = 1'b1;
              kcode = int'(iekq_pkg::VOL_DOWN);
              kval = 1;
              s = 0;
            end else if (s < -thr) begin
              have_key = 1'b1;
              synth = 1'b1;
              kcode = int'(iekq_pkg::VOL_UP);
              kval = 1;
              s = 0;
            end
            motion_sum = s;
          end
        end else if (req.ev_type == iekq_pkg::TYPE_ABS && is_vol) begin
          have_key = 1'b1;
          synth = 1'b1;
        end else begin
          motion_sum = 0;
          if (req.ev_type == iekq_pkg::TYPE_KEY) have_key = 1'b1;
        end
      end
      iekq_pkg::FUNC_REPEAT: begin
        if (vol_held) begin
          motion_sum = 0;
          have_key = 1'b1;
          kcode = int'(held_key);
          kval = 1;
        end
      end
      iekq_pkg::FUNC_POP: begin
        if (ring_count > 0) begin
          res.popped_valid = 1'b1;
          res.popped_key = key_ring[ring_head];
          ring_head = (ring_head + 1) % QUEUE_DEPTH;
          ring_count--;
        end
      end
      iekq_pkg::FUNC_CLEAR: begin
        ring_count = 0;
      end
      iekq_pkg::FUNC_QUERY: begin
        if (req.qkey < KEY_COUNT) res.key_state = key_states[req.qkey];
      end
      default: begin
      end
    endcase
    // key events update the state table and queue presses
    if (have_key && kcode < KEY_COUNT) begin
      res.key_accepted = 1'b1;
      if (!synth) key_states[kcode] = kval[7:0];
      if (kval > 0) begin
        if (ring_count < QUEUE_DEPTH) begin
          key_ring[(ring_head + ring_count) % QUEUE_DEPTH] = kcode[9:0];
          ring_count++;
        end else begin
          res.key_dropped = 1'b1;
        end
      end
    end
    res.queue_count = ring_count[8:0];
    res.repeat_armed = vol_held;
    return res;
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_LIMIT) $display("result %0d: %s", results_seen, what);
    mismatch_count++;
  endtask

  task automatic push_request(input request_t req);
    pending_requests.push_back(req);
    queued_items++;
  endtask

  // raw event; the query key is a don't-care
  task automatic queue_raw(input logic [4:0] t, input logic [15:0] c, input logic [31:0] v);
    request_t req;
    req.func = iekq_pkg::FUNC_RAW;
    req.ev_type = t;
    req.code = c;
    req.value = v;
    req.qkey = 10'($urandom);
    push_request(req);
  endtask

  // non-event request; event fields carry random junk
  task automatic queue_op(input logic [2:0] f, input logic [9:0] q);
    request_t req;
    req.func = f;
    req.ev_type = 5'($urandom);
    req.code = 16'($urandom);
    req.value = $urandom;
    req.qkey = q;
    push_request(req);
  endtask

  // key event, mostly a press of an in-range key
  task automatic queue_key_event();
    logic [15:0] c;
    logic [31:0] v;
    case ($urandom_range(0, 7))
      0: c = 16'd0;
      1: c = 16'(KEY_COUNT - 1);
      2: c = $urandom_range(0, 1) ? iekq_pkg::VOL_UP : iekq_pkg::VOL_DOWN;
      default: c = 16'($urandom_range(0, KEY_COUNT - 1));
    endcase
    case ($urandom_range(0, 9))
      0: v = 32'd0;
      1: v = $urandom | 32'h8000_0000;
      2: v = {1'b0, 31'($urandom)};
      default: v = 32'($urandom_range(1, 255));
    endcase
    queue_raw(iekq_pkg::TYPE_KEY, c, v);
  endtask

  task automatic queue_random_phase(input bit with_fill);
    int          start;
    int          n;
    int          t;
    int          mv;
    logic [15:0] vol;
    start = queued_items;
    // enough presses to fill the ring and overflow it
    if (with_fill) begin
      n = $urandom_range(QUEUE_DEPTH + 4, QUEUE_DEPTH + 20);
      repeat (n) queue_raw(iekq_pkg::TYPE_KEY, 16'($urandom_range(0, KEY_COUNT - 1)),
                           32'($urandom_range(1, 255)));
    end
    t = int'(motion_limit);
    while (queued_items - start < PHASE_ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1: repeat ($urandom_range(1, 10)) queue_key_event();
        2, 3: begin
          // trackball motion around the threshold
          repeat ($urandom_range(2, 8)) begin
            case ($urandom_range(0, 9))
              0: queue_raw(iekq_pkg::TYPE_REL, iekq_pkg::AXIS_Y, $urandom);
              1: queue_raw(iekq_pkg::TYPE_REL, 16'($urandom), $urandom);
              2: queue_raw(iekq_pkg::TYPE_SYN, 16'($urandom), $urandom);
              default: begin
                mv = int'($urandom_range(0, 2 * t + 4)) - (t + 2);
                queue_raw(iekq_pkg::TYPE_REL, iekq_pkg::AXIS_Y, 32'(mv));
              end
            endcase
          end
        end
        4: begin
          // volume hold with auto-repeat, then release
          vol = $urandom_range(0, 1) ? iekq_pkg::VOL_UP : iekq_pkg::VOL_DOWN;
          queue_raw(iekq_pkg::TYPE_KEY, vol, 32'd1);
          repeat ($urandom_range(1, 6)) queue_op(iekq_pkg::FUNC_REPEAT, 10'($urandom));
          queue_raw($urandom_range(0, 3) != 0 ? iekq_pkg::TYPE_KEY : iekq_pkg::TYPE_ABS,
                    vol, 32'd0);
          queue_op(iekq_pkg::FUNC_REPEAT, 10'($urandom));
        end
        5, 6: repeat ($urandom_range(1, 10)) queue_op(iekq_pkg::FUNC_POP, 10'($urandom));
        7: repeat ($urandom_range(1, 4))
          queue_op(iekq_pkg::FUNC_QUERY, 10'($urandom_range(0, 1023)));
        8: begin
          // unconstrained requests
          repeat ($urandom_range(1, 3)) begin
            if ($urandom_range(0, 1)) queue_raw(5'($urandom), 16'($urandom), $urandom);
            else queue_op(3'($urandom), 10'($urandom));
          end
        end
        default: begin
          if ($urandom_range(0, 3) == 0) queue_op(iekq_pkg::FUNC_CLEAR, 10'($urandom));
          else queue_raw(iekq_pkg::TYPE_ABS,
                         $urandom_range(0, 1) ? iekq_pkg::VOL_UP : iekq_pkg::VOL_DOWN,
                         $urandom);
        end
      endcase
    end
  endtask

  // sender pause until every outstanding result has come back
  task automatic wait_for_drain();
    while (pending_requests.size() != 0 || in_push || expected_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) expected_results.push_back(key_event_result(offered));
      if (!in_push || !in_full) begin
        if (pending_requests.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          offered = pending_requests.pop_front();
          in_push <= 1'b1;
          in_func <= offered.func;
          in_event_type <= offered.ev_type;
          in_event_code <= offered.code;
          in_event_value <= offered.value;
          in_query_key <= offered.qkey;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // result monitor and pop control
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transaction with no request outstanding");
        end else begin
          result_want = expected_results.pop_front();
          if (out_key_accepted !== result_want.key_accepted)
            report_mismatch($sformatf("key_accepted %0b, expected %0b",
                                      out_key_accepted, result_want.key_accepted));
          if (out_key_dropped !== result_want.key_dropped)
            report_mismatch($sformatf("key_dropped %0b, expected %0b",
                                      out_key_dropped, result_want.key_dropped));
          if (out_popped_valid !== result_want.popped_valid)
            report_mismatch($sformatf("popped_valid %0b, expected %0b",
                                      out_popped_valid, result_want.popped_valid));
          if (out_popped_key !== result_want.popped_key)
            report_mismatch($sformatf("popped_key %0d, expected %0d",
                                      out_popped_key, result_want.popped_key));
          if (out_queue_count !== result_want.queue_count)
            report_mismatch($sformatf("queue_count %0d, expected %0d",
                                      out_queue_count, result_want.queue_count));
          if (out_key_state !== result_want.key_state)
            report_mismatch($sformatf("key_state 0x%02h, expected 0x%02h",
                                      out_key_state, result_want.key_state));
          if (out_repeat_armed !== result_want.repeat_armed)
            report_mismatch($sformatf("repeat_armed %0b, expected %0b",
                                      out_repeat_armed, result_want.repeat_armed));
        end
        results_seen++;
      end
      // long hold-offs on request, random idling otherwise
      if (hold_left != 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (holds_done != holds_asked) begin
        holds_done++;
        hold_left = $urandom_range(40, 70);
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // watchdog on cycles with no transaction on either side
  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("no transaction for %0d cycles", STALL_LIMIT);
      $display("Verification failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // stimulus and run control
  initial begin
    motion_sum = 0;
    vol_held = 1'b0;
    held_key = '0;
    ring_head = 0;
    ring_count = 0;
    for (int k = 0; k < KEY_COUNT; k++) key_states[k] = '0;
    send_idle_pct = 35;
    recv_idle_pct = 47;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // directed requests at the reset threshold
    queue_op(iekq_pkg::FUNC_QUERY, 10'd0);
    queue_op(iekq_pkg::FUNC_QUERY, 10'(KEY_COUNT - 1));
    queue_op(iekq_pkg::FUNC_QUERY, 10'h3FF);
    queue_op(iekq_pkg::FUNC_POP, 10'd0);
    queue_op(iekq_pkg::FUNC_REPEAT, 10'd0);
    queue_raw(iekq_pkg::TYPE_KEY, iekq_pkg::VOL_UP, 32'd1);
    queue_op(iekq_pkg::FUNC_REPEAT, 10'd0);
    queue_raw(iekq_pkg::TYPE_REL, iekq_pkg::AXIS_Y, 32'd2);
    queue_raw(iekq_pkg::TYPE_REL, iekq_pkg::AXIS_Y, 32'd2);
    queue_raw(iekq_pkg::TYPE_REL, iekq_pkg::AXIS_Y, 32'hFFFF_FFFC);
    queue_raw(iekq_pkg::TYPE_REL, 16'd0, 32'h7FFF_FFFF);
    queue_raw(iekq_pkg::TYPE_REL, iekq_pkg::AXIS_Y, 32'h8000_0000);
    queue_raw(iekq_pkg::TYPE_REL, iekq_pkg::AXIS_Y, 32'h7FFF_FFFF);
    queue_raw(iekq_pkg::TYPE_ABS, iekq_pkg::VOL_DOWN, 32'h0000_FFFF);
    queue_raw(iekq_pkg::TYPE_ABS, iekq_pkg::VOL_UP, 32'hFFFF_FFFB);
    queue_raw(iekq_pkg::TYPE_KEY, 16'(KEY_COUNT - 1), 32'hFFFF_FFAB);
    queue_op(iekq_pkg::FUNC_QUERY, 10'(KEY_COUNT - 1));
    queue_raw(iekq_pkg::TYPE_KEY, 16'(KEY_COUNT), 32'd1);
    queue_raw(iekq_pkg::TYPE_KEY, 16'hFFFF, 32'd1);
    queue_raw(iekq_pkg::TYPE_SYN, 16'hFFFF, 32'hFFFF_FFFF);
    queue_raw(TYPE_TOP, 16'd0, 32'd0);
    queue_op(FUNC_SPARE_LO, 10'd0);
    queue_op(FUNC_SPARE_HI, 10'h3FF);
    queue_op(iekq_pkg::FUNC_POP, 10'd0);
    queue_op(iekq_pkg::FUNC_CLEAR, 10'd0);
    wait_for_drain();

    // random phases, each at its own threshold; the last two share a zero-idle mix
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 47;
        end
        1: begin
          send_idle_pct = 47;
          recv_idle_pct = 35;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      @(posedge clk);
      cfg_we <= 1'b1;
      case (phase)
        0: cfg_data <= 8'd0;
        1: cfg_data <= 8'd255;
        2: cfg_data <= 8'($urandom_range(1, 8));
        default: cfg_data <= 8'($urandom_range(9, 254));
      endcase
      @(posedge clk);
      cfg_we <= 1'b0;
      motion_limit = cfg_data;
      queue_random_phase(phase % 2 == 1);
      holds_asked++;
      wait_for_drain();
    end

    // let any stray result show up before the verdict
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
